### src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Command and status codes, item structs and the controller interface.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int SpqCapacity = 16;

	typedef enum logic [2:0] {
		CMD_INSERT  = 3'd0,
		CMD_PEEK    = 3'd1,
		CMD_DEQUEUE = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_UPDATE  = 3'd4,
		CMD_FIND    = 3'd5,
		CMD_CLEAR   = 3'd6,
		CMD_NOP     = 3'd7
	} spq_cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NEGPRI   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} spq_status_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
		logic signed [15:0] priority_req;
	} spq_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value_out;
		logic signed [15:0] priority_out;
		logic [4:0]         count;
	} spq_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} spq_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the input item
		logic exec;   // search, compute result and update the array
		logic hold;   // keep result register
	} spq_cmd_if_t;

endpackage

### src/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer for the stable priority queue
// Takes an item, runs the execute state, presents the result until taken.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_fire,
	output logic                busy,
	output logic                out_valid,
	output spq_pkg::spq_cmd_if_t cmd
);
	import spq_pkg::*;

	spq_state_t state_q, state_d;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_EXEC;
			S_EXEC: state_d = S_OUT;
			S_OUT: if (out_fire) state_d = in_fire ? S_EXEC : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = 1'b0;
		out_valid = 1'b0;
		cmd.load  = in_fire;
		cmd.exec  = 1'b0;
		cmd.hold  = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			S_OUT: begin
				out_valid = 1'b1;
				busy      = !out_fire;
			end
			default: ;
		endcase
	end

endmodule

### src/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: sorted entry array with parallel compare and shift
// Holds entries in ascending priority order and executes one command.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int CAPACITY = spq_pkg::SpqCapacity
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spq_pkg::spq_cmd_if_t cmd,
	input  spq_pkg::spq_in_t     in_item,
	output spq_pkg::spq_out_t    out_item
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0] val_q [CAPACITY];
	logic [14:0] pri_q [CAPACITY];
	logic [CW-1:0] cnt_q;
	spq_in_t     item_q;
	spq_out_t    res_q;

	logic [CAPACITY-1:0] live, match, first, before_m, after_m;
	logic [CAPACITY-1:0] ins_le;
	logic                found, negp, full;
	logic [14:0]         fpri, newp;
	logic [31:0]         nv [CAPACITY];
	logic [14:0]         np [CAPACITY];
	logic [CW-1:0]       ncnt;
	spq_out_t            res_d;
	logic                do_del, do_ins, del_head;
	logic [31:0]         sv [CAPACITY];
	logic [14:0]         sp [CAPACITY];
	logic [CAPACITY-1:0] slive;

	assign negp = item_q.priority_req[15];
	assign newp = item_q.priority_req[14:0];
	assign full = (cnt_q == CW'(CAPACITY));

	// match vector and first match
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			live[i]  = (CW'(i) < cnt_q);
			match[i] = live[i] && (val_q[i] == item_q.value);
		end
		first = match & (~match + 1'b1);
		found = |match;
		before_m = first - 1'b1;
		fpri = '0;
		for (int i = 0; i < CAPACITY; i++) if (first[i]) fpri = pri_q[i];
	end

	// delete stage: close the gap at the deleted entry, or at the head
	always_comb begin
		after_m = do_del ? ((found && !del_head) ? ~before_m : '1) : '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (after_m[i] && i + 1 < CAPACITY) begin
				sv[i] = val_q[(i + 1) % CAPACITY];
				sp[i] = pri_q[(i + 1) % CAPACITY];
			end else begin
				sv[i] = val_q[i];
				sp[i] = pri_q[i];
			end
			slive[i] = do_del ? (CW'(i + 1) < cnt_q) : live[i];
		end
	end

	// insert stage: open a slot after equal priorities
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ins_le[i] = slive[i] && (sp[i] <= newp);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (!do_ins || ins_le[i]) begin
				nv[i] = sv[i];
				np[i] = sp[i];
			end else if (i == 0 || ins_le[(i + CAPACITY - 1) % CAPACITY]) begin
				nv[i] = item_q.value;
				np[i] = newp;
			end else begin
				nv[i] = sv[(i + CAPACITY - 1) % CAPACITY];
				np[i] = sp[(i + CAPACITY - 1) % CAPACITY];
			end
		end
	end

	// decode command into delete, insert and result
	always_comb begin
		do_del   = 1'b0;
		do_ins   = 1'b0;
		del_head = 1'b0;
		ncnt     = cnt_q;
		res_d    = '0;
		res_d.status = ST_OK;
		unique case (spq_cmd_t'(item_q.command))
			CMD_INSERT: begin
				if (negp) res_d.status = ST_NEGPRI;
				else if (full) res_d.status = ST_FULL;
				else begin
					do_ins = 1'b1;
					ncnt = cnt_q + 1'b1;
				end
			end
			CMD_PEEK, CMD_DEQUEUE: begin
				if (cnt_q == '0) res_d.status = ST_EMPTY;
				else begin
					res_d.value_out = val_q[0];
					if (item_q.command == CMD_DEQUEUE) begin
						do_del   = 1'b1;
						del_head = 1'b1;
						ncnt = cnt_q - 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				if (!found) res_d.status = ST_NOTFOUND;
				else begin
					do_del = 1'b1;
					ncnt = cnt_q - 1'b1;
				end
			end
			CMD_UPDATE: begin
				if (negp) begin
					res_d.status = ST_NEGPRI;
					res_d.priority_out = '1;
				end else if (!found) begin
					res_d.status = ST_NOTFOUND;
					res_d.priority_out = '1;
				end else begin
					do_del = 1'b1;
					do_ins = 1'b1;
					res_d.priority_out = {1'b0, newp};
				end
			end
			CMD_FIND: begin
				if (!found) begin
					res_d.status = ST_NOTFOUND;
					res_d.priority_out = '1;
				end else res_d.priority_out = {1'b0, fpri};
			end
			CMD_CLEAR: ncnt = '0;
			default: ;
		endcase
		res_d.count = 5'(ncnt);
	end

	// hold input item
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
	end

	// advance array and result
	always_ff @(posedge clk) begin
		if (cmd.exec && !cmd.hold) begin
			for (int i = 0; i < CAPACITY; i++) begin
				val_q[i] <= nv[i];
				pri_q[i] <= np[i];
			end
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= ncnt;
		end
	end

	assign out_item = res_q;

endmodule

### src/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top: bounded stable priority queue
// Sorted entry array with insert, peek, dequeue, remove, update, find, clear.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the in channel (in_valid / in_stall) as one item each.
// Every command gives exactly one result item on the out channel
// (out_valid / out_stall) with status, head value, priority and count.
// From acceptance to out_valid the item is first captured into the item
// register, then the parallel match, shift and insert run over the sorted
// array and load the result register. No new item is taken while one is in
// flight; the next item is accepted in the cycle its predecessor's result
// is taken. The search and shift network over all entries is combinational.
// Reset empties the queue; entry contents are not cleared and never read
// beyond the count. While out_stall is high the result holds and in_stall
// stays high, so no further item is taken.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::SpqCapacity
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  spq_pkg::spq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output spq_pkg::spq_out_t out_data
);
	import spq_pkg::*;

	spq_cmd_if_t cmd;
	logic        busy, in_fire, out_fire;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign in_stall = busy;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_fire  (out_fire),
		.busy      (busy),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	spq_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_data),
		.out_item (out_data)
	);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stable priority queue
// Drives a table of directed commands, then random command mixes with random
// idling on both sides, and checks each result item against a behavioral
// model of the sorted queue kept in this file or against a fixed row result.
// ----------------------------------------------------------------------------
module testbench;
	import spq_pkg::*;

	localparam int NumRandom = 1400;
	localparam int IdleLimit = 4000;
	localparam int Cap = SpqCapacity;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	spq_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	spq_out_t out_data;

	stable_priority_queue_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// model of the queue contents
	logic [31:0] q_val [Cap];
	logic [14:0] q_pri [Cap];
	int          q_len;

	// expected result items, oldest first
	spq_out_t pending_results [$];
	int errors = 0;
	int idle_cycles = 0;
	logic stim_done;
	logic quiet;     // no idling in the final stretch
	logic hold_long; // long receiver hold-off request

	// directed rows: command, value, priority, check flag, expected result
	typedef struct {
		spq_cmd_t cmd;
		logic [31:0] val;
		logic [15:0] pri;
		logic fixed;
		spq_out_t exp;
	} row_t;
	row_t rows [$];

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// drop the entry at pos and close the gap
	function automatic void q_drop(int pos);
		for (int i = pos; i + 1 < q_len; i++) begin
			q_val[i] = q_val[i + 1];
			q_pri[i] = q_pri[i + 1];
		end
		q_len--;
	endfunction

	// place behind all equal priorities
	function automatic void q_place(logic [31:0] v, logic [14:0] p);
		int pos;
		pos = 0;
		while (pos < q_len && q_pri[pos] <= p) pos++;
		for (int i = q_len; i > pos; i--) begin
			q_val[i] = q_val[i - 1];
			q_pri[i] = q_pri[i - 1];
		end
		q_val[pos] = v;
		q_pri[pos] = p;
		q_len++;
	endfunction

	function automatic int q_search(logic [31:0] v);
		for (int i = 0; i < q_len; i++)
			if (q_val[i] == v) return i;
		return q_len;
	endfunction

	// compute the result of one command and advance the model
	function automatic spq_out_t queue_predict(spq_in_t it);
		spq_out_t r;
		logic neg;
		logic [14:0] p;
		int pos;
		r = '0;
		neg = it.priority_req[15];
		p = it.priority_req[14:0];
		r.status = ST_OK;
		case (spq_cmd_t'(it.command))
			CMD_INSERT: begin
				if (neg) r.status = ST_NEGPRI;
				else if (q_len >= Cap) r.status = ST_FULL;
				else q_place(it.value, p);
			end
			CMD_PEEK, CMD_DEQUEUE: begin
				if (q_len == 0) r.status = ST_EMPTY;
				else begin
					r.value_out = q_val[0];
					if (it.command == CMD_DEQUEUE) q_drop(0);
				end
			end
			CMD_REMOVE: begin
				pos = q_search(it.value);
				if (pos >= q_len) r.status = ST_NOTFOUND;
				else q_drop(pos);
			end
			CMD_UPDATE: begin
				if (neg) begin
					r.status = ST_NEGPRI;
					r.priority_out = '1;
				end else begin
					pos = q_search(it.value);
					if (pos >= q_len) begin
						r.status = ST_NOTFOUND;
						r.priority_out = '1;
					end else begin
						q_drop(pos);
						q_place(it.value, p);
						r.priority_out = {1'b0, p};
					end
				end
			end
			CMD_FIND: begin
				pos = q_search(it.value);
				if (pos >= q_len) begin
					r.status = ST_NOTFOUND;
					r.priority_out = '1;
				end else r.priority_out = {1'b0, q_pri[pos]};
			end
			CMD_CLEAR: q_len = 0;
			default: ;
		endcase
		r.count = q_len[4:0];
		return r;
	endfunction

	// pick a value from a small pool so matches are common
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7fff_fffc | $urandom_range(0, 3);
			default: return $urandom_range(0, 23);
		endcase
	endfunction

	function automatic logic [15:0] pick_priority();
		case ($urandom_range(0, 11))
			0: return 16'h8000 | $urandom();
			1: return 16'h7fff;
			2: return $urandom_range(0, 16'h7fff);
			default: return $urandom_range(0, 5);
		endcase
	endfunction

	// pick a command, biased by phase to sweep empty to full
	function automatic spq_cmd_t pick_command(int phase);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return CMD_CLEAR;
		if (r < 3) return CMD_NOP;
		if (phase == 0) begin
			if (r < 55) return CMD_INSERT;
		end else if (r < 25) return CMD_INSERT;
		if (r < 65) return CMD_DEQUEUE;
		if (r < 72) return CMD_PEEK;
		if (r < 80) return CMD_REMOVE;
		if (r < 90) return CMD_UPDATE;
		return CMD_FIND;
	endfunction

	function automatic row_t mk_row(spq_cmd_t c, logic [31:0] v, logic [15:0] p);
		row_t r;
		r.cmd = c;
		r.val = v;
		r.pri = p;
		r.fixed = 1'b0;
		r.exp = '0;
		return r;
	endfunction

	function automatic row_t mk_fixed(spq_cmd_t c, logic [31:0] v, logic [15:0] p,
			spq_status_t s, logic [31:0] vo, logic [15:0] po, logic [4:0] n);
		row_t r;
		r = mk_row(c, v, p);
		r.fixed = 1'b1;
		r.exp.status = s;
		r.exp.value_out = vo;
		r.exp.priority_out = po;
		r.exp.count = n;
		return r;
	endfunction

	// offer one item and hold it until accepted
	task automatic send_item(spq_in_t it, logic allow_gap);
		if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stimulus
	initial begin
		spq_in_t it;
		spq_out_t e, m;
		in_valid = 1'b0;
		in_data = '0;
		stim_done = 1'b0;
		quiet = 1'b0;
		hold_long = 1'b0;
		q_len = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, extremes, stability, full, errors
		rows.push_back(mk_fixed(CMD_PEEK, 0, 0, ST_EMPTY, 0, 0, 0));
		rows.push_back(mk_fixed(CMD_DEQUEUE, 0, 0, ST_EMPTY, 0, 0, 0));
		rows.push_back(mk_fixed(CMD_REMOVE, 5, 0, ST_NOTFOUND, 0, 0, 0));
		rows.push_back(mk_fixed(CMD_FIND, 5, 0, ST_NOTFOUND, 0, 16'hffff, 0));
		rows.push_back(mk_fixed(CMD_UPDATE, 5, 3, ST_NOTFOUND, 0, 16'hffff, 0));
		rows.push_back(mk_fixed(CMD_INSERT, 1, 16'h8000, ST_NEGPRI, 0, 0, 0));
		rows.push_back(mk_fixed(CMD_INSERT, 32'h8000_0000, 16'h7fff, ST_OK, 0, 0, 1));
		rows.push_back(mk_fixed(CMD_INSERT, 32'h7fff_ffff, 0, ST_OK, 0, 0, 2));
		rows.push_back(mk_row(CMD_INSERT, 32'hffff_ffff, 0));
		rows.push_back(mk_fixed(CMD_UPDATE, 7, 16'hffff, ST_NEGPRI, 0, 16'hffff, 3));
		rows.push_back(mk_fixed(CMD_PEEK, 0, 0, ST_OK, 32'h7fff_ffff, 0, 3));
		rows.push_back(mk_row(CMD_FIND, 32'h8000_0000, 0));
		rows.push_back(mk_row(CMD_UPDATE, 32'h7fff_ffff, 0));
		rows.push_back(mk_row(CMD_DEQUEUE, 0, 0));
		rows.push_back(mk_row(CMD_NOP, 32'hffff_ffff, 16'hffff));
		for (int i = 0; i < 14; i++) rows.push_back(mk_row(CMD_INSERT, i, i % 3));
		rows.push_back(mk_fixed(CMD_INSERT, 99, 1, ST_FULL, 0, 0, 16));
		rows.push_back(mk_row(CMD_REMOVE, 4, 0));
		rows.push_back(mk_fixed(CMD_CLEAR, 0, 0, ST_OK, 0, 0, 0));

		foreach (rows[k]) begin
			it.command = rows[k].cmd;
			it.value = rows[k].val;
			it.priority_req = rows[k].pri;
			m = queue_predict(it);
			e = rows[k].fixed ? rows[k].exp : m;
			pending_results.push_back(e);
			send_item(it, 1'b1);
		end

		// random: alternate fill-heavy and drain-heavy phases
		for (int n = 0; n < NumRandom; n++) begin
			if (n == 300) hold_long <= 1'b1;
			if (n == 320) hold_long <= 1'b0;
			if (n == NumRandom - 150) quiet <= 1'b1;
			it.command = pick_command((n / 60) % 2);
			it.value = pick_value();
			it.priority_req = pick_priority();
			if (it.command == CMD_REMOVE || it.command == CMD_UPDATE ||
					it.command == CMD_FIND) begin
				if (q_len > 0 && $urandom_range(0, 3) != 0)
					it.value = q_val[$urandom_range(0, q_len - 1)];
			end
			pending_results.push_back(queue_predict(it));
			send_item(it, 1'b1);
		end
		in_valid <= 1'b0;
		stim_done <= 1'b1;
	end

	// receiver: random stall bursts plus repeated long hold-offs while hold_long is set
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold = 200;
				out_stall <= 1'b1;
				while (hold > 0) begin
					@(posedge clk);
					hold--;
				end
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		spq_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result item %p", out_data);
			end else begin
				e = pending_results.pop_front();
				if (out_data.status !== e.status || out_data.value_out !== e.value_out ||
						out_data.priority_out !== e.priority_out ||
						out_data.count !== e.count) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", e, out_data);
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		fork
			begin
				wait (stim_done && pending_results.size() == 0);
				repeat (10) @(posedge clk);
				if (errors == 0 && pending_results.size() == 0)
					$display("[stable_priority_queue_top] OK");
				else
					$display("[stable_priority_queue_top] ERROR");
			end
			begin
				wait (idle_cycles >= IdleLimit);
				$display("[stable_priority_queue_top] ERROR");
			end
		join_any
		$finish;
	end

endmodule

### stable_priority_queue_top.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue_top.sv
bench/testbench.sv
